>>> hdl/rkf_pkg.sv
// Package with the shared types, constants and helper function of the key lighting engine.
`default_nettype none

package rkf_pkg;

    localparam int KEY_W     = 7;
    localparam int KEY_EXT_W = 11;
    localparam int COLOR_W   = 24;
    localparam int COUNT_W   = 16;
    localparam int ENTRY_W   = 1 + COUNT_W + COLOR_W;
    localparam int CFG_AW    = 2;
    localparam int QDEPTH    = 4;
    localparam int QPW       = 2;

    localparam logic [31:0] LFSR_TAPS = 32'hD000_0001;
    localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

    localparam logic [CFG_AW-1:0] CFG_PRESS_COLOR = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_RANDOM_MODE = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_FADE_FRAMES = 2'd2;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] press_color;
        logic               random_mode;
        logic [COUNT_W-1:0] fade_frames;
    } t_cfg;

    typedef struct packed {
        logic             is_render;
        logic             in_range;
        logic [KEY_W-1:0] key;
        logic             down;
    } t_item;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_MULT,
        ST_SAT,
        ST_DIV,
        ST_RESULT
    } t_state;

    function automatic logic [31:0] lfsr_next(input logic [31:0] x);
        logic [31:0] y;
        y = {1'b0, x[31:1]};
        if (x[0]) begin
            y = y ^ LFSR_TAPS;
        end
        return y;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rkf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module rkf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hdl/rkf_front.sv
// Front end: accepts items, classifies them and holds them in a short queue for the back end.
`default_nettype none

module rkf_front #(
    parameter int KEYS = 128
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic                  i_action,
    input  wire logic [rkf_pkg::KEY_W-1:0] i_key_index,
    input  wire logic                  i_key_down,
    input  wire logic                  i_clearing,
    output logic                       o_head_valid,
    output rkf_pkg::t_item             o_head,
    input  wire logic                  i_head_pop
);

    import rkf_pkg::*;

    t_item              r_q [QDEPTH];
    logic [QPW-1:0]     r_wr_ptr;
    logic [QPW-1:0]     r_rd_ptr;
    logic [QPW:0]       r_count;
    logic [KEY_EXT_W-1:0] key_ext;
    t_item              item;
    logic               push_ok;
    logic               pop_ok;

    assign key_ext        = {{(KEY_EXT_W - KEY_W){1'b0}}, i_key_index};
    assign item.is_render = (i_action == ACT_RENDER);
    assign item.in_range  = (key_ext < KEY_EXT_W'(KEYS));
    assign item.key       = i_key_index;
    assign item.down      = i_key_down;

    assign o_full       = (r_count == (QPW + 1)'(QDEPTH)) || i_clearing;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];
    assign push_ok      = i_push && !o_full;
    assign pop_ok       = i_head_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/rkf_back.sv
// Back end: key table sequencer with the fade multiply, the iterative divider and the result register.
`default_nettype none

module rkf_back #(
    parameter int KEYS = 128
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rkf_pkg::t_cfg             i_cfg,
    input  wire logic                      i_head_valid,
    input  wire rkf_pkg::t_item            i_head,
    output logic                           o_head_pop,
    output logic                           o_clearing,
    output logic                           o_empty,
    input  wire logic                      i_pop,
    output logic [rkf_pkg::KEY_W-1:0]      o_out_key,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue
);

    import rkf_pkg::*;

    localparam int AW = (KEYS > 1) ? $clog2(KEYS) : 1;

    t_state               r_state;
    t_state               n_state;
    logic [AW-1:0]        r_clr_addr;
    t_item                r_item;
    logic [31:0]          r_lfsr;
    logic [2:0][7:0]      r_color;
    logic [COUNT_W-1:0]   r_cnt;
    logic [1:0]           r_ch;
    logic [23:0]          r_prod;
    logic [COUNT_W-1:0]   r_rem;
    logic [7:0]           r_quo;
    logic [2:0]           r_step;
    logic [2:0][7:0]      r_res;
    logic                 r_out_valid;
    logic [KEY_W-1:0]     r_out_key;
    logic [2:0][7:0]      r_out_res;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 rd_held;
    logic [COUNT_W-1:0]   rd_count;
    logic [COLOR_W-1:0]   rd_color;
    logic [31:0]          lfsr1;
    logic [31:0]          lfsr2;
    logic [31:0]          lfsr3;
    logic [COLOR_W-1:0]   new_color;
    logic [ENTRY_W-1:0]   sample_entry;
    logic                 new_press;
    logic                 sat;
    logic [COUNT_W:0]     trial;
    logic                 trial_ge;
    logic [COUNT_W:0]     trial_diff;
    logic                 qbit;
    logic                 last_ch;
    logic                 out_free;

    rkf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (KEYS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign ram_raddr = AW'({{(KEY_EXT_W - KEY_W){1'b0}}, i_head.key});
    assign rd_held   = ram_rdata[ENTRY_W-1];
    assign rd_count  = ram_rdata[COLOR_W +: COUNT_W];
    assign rd_color  = ram_rdata[COLOR_W-1:0];

    assign lfsr1     = lfsr_next(r_lfsr);
    assign lfsr2     = lfsr_next(lfsr1);
    assign lfsr3     = lfsr_next(lfsr2);
    assign new_press = r_item.down && !rd_held;
    assign new_color = !new_press ? rd_color :
                       i_cfg.random_mode ? {lfsr3[7:0], lfsr2[7:0], lfsr1[7:0]} :
                       i_cfg.press_color;
    assign sample_entry = r_item.down ? {1'b1, i_cfg.fade_frames, new_color}
                                      : {1'b0, rd_count, rd_color};

    assign sat        = (r_prod >= {i_cfg.fade_frames, 8'h00});
    assign trial      = {r_rem, r_quo[7]};
    assign trial_ge   = (trial >= {1'b0, i_cfg.fade_frames});
    assign trial_diff = trial - {1'b0, i_cfg.fade_frames};
    assign qbit       = trial_ge;
    assign last_ch    = (r_ch == 2'd2);
    assign out_free   = !r_out_valid || i_pop;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(KEYS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.in_range) begin
                        n_state = ST_EVAL;
                    end else if (i_head.is_render) begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_EVAL: begin
                if (!r_item.is_render) begin
                    n_state = ST_IDLE;
                end else if (!rd_held && rd_count != '0 && i_cfg.fade_frames != '0) begin
                    n_state = ST_MULT;
                end else begin
                    n_state = ST_RESULT;
                end
            end
            ST_MULT: begin
                n_state = ST_SAT;
            end
            ST_SAT: begin
                if (!sat) begin
                    n_state = ST_DIV;
                end else if (last_ch) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_MULT;
                end
            end
            ST_DIV: begin
                if (r_step == 3'd7) begin
                    n_state = last_ch ? ST_RESULT : ST_MULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = AW'({{(KEY_EXT_W - KEY_W){1'b0}}, r_item.key});
        ram_wdata  = '0;
        o_head_pop = 1'b0;
        o_clearing = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                o_clearing = 1'b1;
            end
            ST_IDLE: begin
                o_head_pop = i_head_valid;
            end
            ST_EVAL: begin
                if (!r_item.is_render) begin
                    ram_we    = 1'b1;
                    ram_wdata = sample_entry;
                end else if (!rd_held && rd_count != '0) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b0, rd_count - 1'b1, rd_color};
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_head_valid) begin
                    r_item <= i_head;
                    r_res  <= '0;
                end
            end
            ST_EVAL: begin
                r_color <= rd_color;
                r_cnt   <= rd_count;
                r_ch    <= 2'd0;
                if (rd_held || rd_count != '0) begin
                    r_res <= rd_color;
                end
            end
            ST_MULT: begin
                r_prod <= {16'h0000, r_color[r_ch]} * {8'h00, r_cnt};
            end
            ST_SAT: begin
                if (sat) begin
                    r_res[r_ch] <= 8'hFF;
                    r_ch        <= r_ch + 1'b1;
                end else begin
                    r_rem  <= r_prod[23:8];
                    r_quo  <= r_prod[7:0];
                    r_step <= 3'd0;
                end
            end
            ST_DIV: begin
                r_rem  <= trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
                r_quo  <= {r_quo[6:0], qbit};
                r_step <= r_step + 1'b1;
                if (r_step == 3'd7) begin
                    r_res[r_ch] <= {r_quo[6:0], qbit};
                    r_ch        <= r_ch + 1'b1;
                end
            end
            default: begin
                r_ch <= r_ch;
            end
        endcase
        if (r_state == ST_RESULT && out_free) begin
            r_out_key <= r_item.key;
            r_out_res <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (r_state == ST_EVAL && !r_item.is_render && new_press && i_cfg.random_mode) begin
                r_lfsr <= lfsr3;
            end
            if (r_state == ST_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty   = !r_out_valid;
    assign o_out_key = r_out_key;
    assign o_red     = r_out_res[0];
    assign o_green   = r_out_res[1];
    assign o_blue    = r_out_res[2];

endmodule

`default_nettype wire

>>> hdl/reactive_key_fade_lighting.sv
// The back end takes one item at a time and pops the next when done with the last. A sample
// item reads and rewrites its key's table entry, one outside the table is dropped. A render of
// a held or dark key reads its entry and gives the result, one of an unknown key gives it
// at once. A fading key runs a multiply and the 8-step divider once per channel, and a
// saturating channel skips the divider. Reset is synchronous and active low; afterwards the
// key table is cleared while full stays high, and configuration writes are taken throughout.
`default_nettype none

module reactive_key_fade_lighting #(
    parameter int KEYS = 128
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    output logic                           o_full,
    input  wire logic                      i_action,
    input  wire logic [rkf_pkg::KEY_W-1:0] i_key_index,
    input  wire logic                      i_key_down,
    output logic                           o_empty,
    input  wire logic                      i_pop,
    output logic [rkf_pkg::KEY_W-1:0]      o_out_key,
    output logic [7:0]                     o_red,
    output logic [7:0]                     o_green,
    output logic [7:0]                     o_blue,
    input  wire logic                      i_cfg_we,
    input  wire logic [rkf_pkg::CFG_AW-1:0] i_cfg_addr,
    input  wire logic [rkf_pkg::COLOR_W-1:0] i_cfg_data
);

    import rkf_pkg::*;

    t_cfg   r_cfg;
    t_item  head;
    logic   head_valid;
    logic   head_pop;
    logic   clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_color <= 24'hFF_FFFF;
            r_cfg.random_mode <= 1'b0;
            r_cfg.fade_frames <= 16'd30;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PRESS_COLOR: r_cfg.press_color <= i_cfg_data;
                CFG_RANDOM_MODE: r_cfg.random_mode <= i_cfg_data[0];
                CFG_FADE_FRAMES: r_cfg.fade_frames <= i_cfg_data[COUNT_W-1:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    rkf_front #(
        .KEYS (KEYS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_action     (i_action),
        .i_key_index  (i_key_index),
        .i_key_down   (i_key_down),
        .i_clearing   (clearing),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_head_pop   (head_pop)
    );

    rkf_back #(
        .KEYS (KEYS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_head_pop   (head_pop),
        .o_clearing   (clearing),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_out_key    (o_out_key),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

endmodule

`default_nettype wire
